@@ hdl/pnrp_pkg.sv @@
// ----------------------------------------------------------------------------
// pnrp_pkg - shared types and constants
// Record kinds, parse phases and the front-to-back beat format.
// ----------------------------------------------------------------------------
package pnrp_pkg;

	localparam int LENGTH_BITS = 24;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	localparam logic [3:0] KIND_TASK_ID    = 4'd0;
	localparam logic [3:0] KIND_ERR_CODE   = 4'd1;
	localparam logic [3:0] KIND_LINE_START = 4'd2;
	localparam logic [3:0] KIND_TEXT       = 4'd3;
	localparam logic [3:0] KIND_RATE       = 4'd4;
	localparam logic [3:0] KIND_LINE_END   = 4'd9;
	localparam logic [3:0] KIND_DONE       = 4'd10;

	localparam logic [2:0] PH_TAG     = 3'd0;
	localparam logic [2:0] PH_VALUE   = 3'd1;
	localparam logic [2:0] PH_LENGTH  = 3'd2;
	localparam logic [2:0] PH_FIXED   = 3'd3;
	localparam logic [2:0] PH_TEXT    = 3'd4;
	localparam logic [2:0] PH_SKIP    = 3'd5;
	localparam logic [2:0] PH_DISCARD = 3'd6;

	localparam logic [2:0] ERR_LINE  = 3'b001;
	localparam logic [2:0] ERR_BLOCK = 3'b010;
	localparam logic [2:0] ERR_TOP   = 3'b100;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] value;
		logic        ok;
	} rec_t;

	typedef struct packed {
		logic [1:0] count;
		rec_t       r0;
		rec_t       r1;
		rec_t       r2;
	} group_t;

endpackage

@@ hdl/pnrp_front.sv @@
// ----------------------------------------------------------------------------
// pnrp_front - byte classifier
// Walks the wire format one byte per beat and emits the records of each beat
// as one group of up to three.
// ----------------------------------------------------------------------------
module pnrp_front import pnrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output group_t     grp
);

	typedef logic [LENGTH_BITS-1:0] len_t;

	logic [1:0]  lvl_q;
	len_t        blk_q, line_q, skip_q;
	logic [63:0] acc_q;
	logic [3:0]  vcnt_q;
	logic [2:0]  ph_q;
	logic [31:0] fn_q;
	logic [2:0]  wk_q;
	logic [31:0] word_q;
	logic [1:0]  wcnt_q;
	logic [2:0]  err_q;

	logic [1:0]  lvl;
	len_t        blk, line, skip;
	logic [63:0] acc, v;
	logic [3:0]  vcnt;
	logic [2:0]  ph;
	logic [31:0] fn;
	logic [2:0]  wk;
	logic [31:0] word;
	logic [1:0]  wcnt;
	logic [2:0]  err;
	rec_t        recs [3];
	logic [1:0]  n;
	logic        len_bad;
	logic [5:0]  sh;

	function automatic logic [2:0] lvl_err(input logic [1:0] l);
		return (l == 2'd2) ? ERR_LINE : (l == 2'd1) ? ERR_BLOCK : ERR_TOP;
	endfunction

	always_comb begin
		lvl = lvl_q; blk = blk_q; line = line_q; skip = skip_q;
		acc = acc_q; vcnt = vcnt_q; ph = ph_q; fn = fn_q; wk = wk_q;
		word = word_q; wcnt = wcnt_q; err = err_q;
		n = 2'd0; v = '0; len_bad = 1'b0; sh = '0;
		for (int i = 0; i < 3; i++) recs[i] = '{kind: KIND_DONE, value: '0, ok: 1'b1};

		if ((err_q & ERR_TOP) == 3'b0) begin
			if (lvl >= 2'd1) blk = blk - len_t'(1);
			if (lvl == 2'd2) line = line - len_t'(1);
			case (ph_q)
				PH_TAG, PH_VALUE, PH_LENGTH: begin
					if (vcnt >= 4'd9) begin
						err = err | lvl_err(lvl); ph = PH_DISCARD; acc = '0; vcnt = '0;
					end else begin
						sh = 6'(7 * vcnt);
						acc = acc | (64'(data_byte[6:0]) << sh);
						vcnt = vcnt + 4'd1;
						if (!data_byte[7]) begin
							v = acc; acc = '0; vcnt = '0;
							if (ph_q == PH_TAG) begin
								fn = 32'(v >> 3);
								wk = v[2:0];
								if (lvl == 2'd0 && (fn == 32'd2 || fn == 32'd3)) begin
									if (wk != 3'd0) begin
										err = err | lvl_err(lvl); ph = PH_DISCARD;
									end else ph = PH_VALUE;
								end else if ((lvl == 2'd0 && fn == 32'd4) ||
										(lvl == 2'd1 && fn == 32'd1) ||
										(lvl == 2'd2 && fn == 32'd2)) begin
									if (wk != 3'd2) begin
										err = err | lvl_err(lvl); ph = PH_DISCARD;
									end else ph = PH_LENGTH;
								end else if (lvl == 2'd2 && (fn == 32'd3 ||
										(fn >= 32'd5 && fn <= 32'd8))) begin
									if (wk != 3'd5) begin
										err = err | lvl_err(lvl); ph = PH_DISCARD;
									end else begin
										ph = PH_FIXED; word = '0; wcnt = '0;
									end
								end else begin
									case (wk)
										3'd0: ph = PH_VALUE;
										3'd1: begin skip = len_t'(8); ph = PH_SKIP; end
										3'd2: ph = PH_LENGTH;
										3'd5: begin skip = len_t'(4); ph = PH_SKIP; end
										default: begin err = err | lvl_err(lvl); ph = PH_DISCARD; end
									endcase
								end
							end else if (ph_q == PH_VALUE) begin
								if (lvl == 2'd0 && (fn == 32'd2 || fn == 32'd3)) begin
									recs[0] = '{kind: (fn == 32'd2) ? KIND_TASK_ID : KIND_ERR_CODE,
										value: v[31:0], ok: 1'b1};
									n = 2'd1;
								end
								ph = PH_TAG;
							end else begin
								if (lvl == 2'd0) len_bad = (v >> LENGTH_BITS) != 64'd0;
								else if (lvl == 2'd1) len_bad = v > 64'(blk);
								else len_bad = v > 64'(line);
								if (len_bad) begin
									err = err | lvl_err(lvl); ph = PH_DISCARD;
								end else if (lvl == 2'd0 && fn == 32'd4) begin
									lvl = 2'd1; blk = v[LENGTH_BITS-1:0]; ph = PH_TAG;
								end else if (lvl == 2'd1 && fn == 32'd1) begin
									lvl = 2'd2; line = v[LENGTH_BITS-1:0]; ph = PH_TAG;
									recs[0] = '{kind: KIND_LINE_START, value: v[31:0], ok: 1'b1};
									n = 2'd1;
								end else if (v[LENGTH_BITS-1:0] == '0) begin
									ph = PH_TAG;
								end else begin
									skip = v[LENGTH_BITS-1:0];
									ph = (lvl == 2'd2 && fn == 32'd2) ? PH_TEXT : PH_SKIP;
								end
							end
						end
					end
				end
				PH_FIXED: begin
					if (wcnt < 2'd3) begin
						word = word | (32'(data_byte) << {wcnt, 3'b000});
						wcnt = wcnt + 2'd1;
					end else begin
						recs[0] = '{kind: (fn == 32'd3) ? KIND_RATE : fn[3:0],
							value: word | {data_byte, 24'd0}, ok: 1'b1};
						n = 2'd1; word = '0; wcnt = '0; ph = PH_TAG;
					end
				end
				PH_TEXT: begin
					recs[0] = '{kind: KIND_TEXT, value: 32'(data_byte), ok: 1'b1};
					n = 2'd1;
					skip = skip - len_t'(1);
					if (skip == '0) ph = PH_TAG;
				end
				PH_SKIP: begin
					skip = skip - len_t'(1);
					if (skip == '0) ph = PH_TAG;
				end
				default: ;
			endcase

			if (lvl == 2'd2 && line == '0) begin
				if (ph != PH_TAG) err = err | ERR_LINE;
				recs[n] = '{kind: KIND_LINE_END, value: '0, ok: ~err[0]};
				n = n + 2'd1;
				err = err & ~ERR_LINE; acc = '0; vcnt = '0; lvl = 2'd1; ph = PH_TAG;
			end
			if (lvl == 2'd1 && blk == '0) begin
				err = err & ~ERR_BLOCK; acc = '0; vcnt = '0; lvl = 2'd0; ph = PH_TAG;
			end
		end

		if (last_byte) begin
			if (lvl != 2'd0 || ph != PH_TAG) err = err | ERR_TOP;
			recs[n] = '{kind: KIND_DONE, value: '0, ok: ~err[2]};
			n = n + 2'd1;
			lvl = '0; blk = '0; line = '0; skip = '0; acc = '0; vcnt = '0; ph = PH_TAG;
			fn = '0; wk = '0; word = '0; wcnt = '0; err = '0;
		end

		grp = '{count: n, r0: recs[0], r1: recs[1], r2: recs[2]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0; blk_q <= '0; line_q <= '0; skip_q <= '0; acc_q <= '0;
			vcnt_q <= '0; ph_q <= PH_TAG; fn_q <= '0; wk_q <= '0; word_q <= '0;
			wcnt_q <= '0; err_q <= '0;
		end else if (step) begin
			lvl_q <= lvl; blk_q <= blk; line_q <= line; skip_q <= skip; acc_q <= acc;
			vcnt_q <= vcnt; ph_q <= ph; fn_q <= fn; wk_q <= wk; word_q <= word;
			wcnt_q <= wcnt; err_q <= err;
		end
	end

endmodule

@@ hdl/pnrp_queue.sv @@
// ----------------------------------------------------------------------------
// pnrp_queue - group queue
// Small FIFO of record groups between the classifier and the emitter.
// ----------------------------------------------------------------------------
module pnrp_queue import pnrp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output group_t head
);

	group_t              mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign full  = cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QUEUE_AW'(1);
			if (pop) rd_q <= rd_q + QUEUE_AW'(1);
			cnt_q <= cnt_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
		end
	end

endmodule

@@ hdl/pnrp_back.sv @@
// ----------------------------------------------------------------------------
// pnrp_back - record emitter
// Serialises each group into output beats and marks the last of each group.
// ----------------------------------------------------------------------------
module pnrp_back import pnrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	input  group_t      head,
	output logic        pop,
	output logic        valid,
	input  logic        ready,
	output logic [3:0]  record_kind,
	output logic [31:0] record_value,
	output logic        record_ok,
	output logic        last_of_run
);

	logic [1:0] idx_q;
	rec_t       cur;

	always_comb begin
		case (idx_q)
			2'd0:    cur = head.r0;
			2'd1:    cur = head.r1;
			default: cur = head.r2;
		endcase
	end

	assign valid        = !empty && head.count != 2'd0;
	assign record_kind  = cur.kind;
	assign record_value = cur.value;
	assign record_ok    = cur.ok;
	assign last_of_run  = (idx_q + 2'd1) == head.count;
	assign pop = !empty && (head.count == 2'd0 || (ready && last_of_run));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) idx_q <= '0;
		else if (pop) idx_q <= '0;
		else if (valid && ready) idx_q <= idx_q + 2'd1;
	end

endmodule

@@ hdl/protobuf_nested_response_parser_core.sv @@
// ----------------------------------------------------------------------------
// protobuf_nested_response_parser_core - nested response parser
// Channel   Handshake        Payload
// in        in_valid/ready   data_byte, last_byte
// out       out_valid/ready  record_kind, record_value, record_ok, last_of_run
// One byte per cycle enters the classifier while the queue has room; its
// records (up to three) queue as one group. The group is registered in the
// queue before the emitter sends its first record beat. The emitter sends one
// record beat per cycle while out_ready is high; a byte with k records gives k
// beats, and one with none leaves the queue with no beat. Input stalls only
// when the four-group queue is full. Reset clears parser state and the queue.
// ----------------------------------------------------------------------------
module protobuf_nested_response_parser_core import pnrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  record_kind,
	output logic [31:0] record_value,
	output logic        record_ok,
	output logic        last_of_run
);

	group_t grp, head;
	logic   full, empty, pop, step;

	assign in_ready = !full;
	assign step     = in_valid && in_ready;

	pnrp_front u_front (.clk, .arst_n, .step, .data_byte, .last_byte, .grp);

	pnrp_queue u_queue (.clk, .arst_n, .push(step), .push_data(grp), .full,
		.pop, .empty, .head);

	pnrp_back u_back (.clk, .arst_n, .empty, .head, .pop, .valid(out_valid),
		.ready(out_ready), .record_kind, .record_value, .record_ok, .last_of_run);

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !full) else $error("push into full queue");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && record_kind == KIND_DONE) |-> last_of_run)
		else $error("done record not last of run");
`endif

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench - nested response parser check
// Feeds whole encoded responses, clean and damaged, byte by byte into the
// parser, mirrors its decoding in a local model and compares every record beat.
// ----------------------------------------------------------------------------
module testbench;
	import pnrp_pkg::*;

	typedef logic [7:0] byte_q_t[$];
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} in_beat_t;
	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] value;
		logic        ok;
		logic        last;
	} rec_beat_t;

	logic        clk, arst_n;
	logic        in_valid, in_ready, last_byte;
	logic [7:0]  data_byte;
	logic        out_valid, out_ready, record_ok, last_of_run;
	logic [3:0]  record_kind;
	logic [31:0] record_value;

	protobuf_nested_response_parser_core uut (.*);

	in_beat_t  byte_stream[$];
	rec_beat_t expected_recs[$];
	rec_beat_t step_recs[$];
	int        fail_count, bytes_sent, recs_seen, msgs_built, stall_cycles;
	logic      in_took;

	// decoder mirror
	logic [1:0]  lvl;
	logic [23:0] blk_left, line_left, skip_left;
	logic [63:0] acc;
	int          acc_n, word_n;
	logic [2:0]  phase, wkind, errs;
	logic [31:0] fnum, word;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	task automatic clear_decoder();
		lvl = 0; blk_left = 0; line_left = 0; skip_left = 0; acc = 0; acc_n = 0;
		phase = PH_TAG; wkind = 0; errs = 0; fnum = 0; word = 0; word_n = 0;
	endtask

	task automatic add_rec(logic [3:0] k, logic [31:0] v, logic ok);
		rec_beat_t r;
		r = '{kind: k, value: v, ok: ok, last: 1'b0};
		if (step_recs.size() < 4)
			step_recs = {step_recs, r};
	endtask

	task automatic flag_error();
		if (lvl == 2) errs |= ERR_LINE;
		else if (lvl == 1) errs |= ERR_BLOCK;
		else errs |= ERR_TOP;
		phase = PH_DISCARD; acc = 0; acc_n = 0;
	endtask

	task automatic start_skip(logic [31:0] cnt);
		if (cnt == 0) phase = PH_TAG;
		else begin
			skip_left = cnt[23:0]; phase = PH_SKIP;
		end
	endtask

	task automatic take_tag(logic [63:0] t);
		logic [31:0] fn;
		fn = t[34:3];
		fnum = fn; wkind = t[2:0];
		if (lvl == 0 && (fn == 2 || fn == 3)) begin
			if (wkind != 0) flag_error(); else phase = PH_VALUE;
		end else if ((lvl == 0 && fn == 4) || (lvl == 1 && fn == 1) || (lvl == 2 && fn == 2)) begin
			if (wkind != 2) flag_error(); else phase = PH_LENGTH;
		end else if (lvl == 2 && (fn == 3 || (fn >= 5 && fn <= 8))) begin
			if (wkind != 5) flag_error();
			else begin
				phase = PH_FIXED; word = 0; word_n = 0;
			end
		end else begin
			case (wkind)
				3'd0: phase = PH_VALUE;
				3'd1: start_skip(8);
				3'd2: phase = PH_LENGTH;
				3'd5: start_skip(4);
				default: flag_error();
			endcase
		end
	endtask

	task automatic take_length(logic [63:0] len);
		if (lvl == 0 && len[63:LENGTH_BITS] != 0) begin
			flag_error(); return;
		end
		if (lvl == 1 && len > {40'd0, blk_left}) begin
			flag_error(); return;
		end
		if (lvl == 2 && len > {40'd0, line_left}) begin
			flag_error(); return;
		end
		if (lvl == 0 && fnum == 4) begin
			lvl = 1; blk_left = len[23:0]; phase = PH_TAG;
		end else if (lvl == 1 && fnum == 1) begin
			lvl = 2; line_left = len[23:0]; phase = PH_TAG;
			add_rec(KIND_LINE_START, len[31:0], 1'b1);
		end else if (lvl == 2 && fnum == 2) begin
			if (len == 0) phase = PH_TAG;
			else begin
				skip_left = len[23:0]; phase = PH_TEXT;
			end
		end else
			start_skip(len[31:0]);
	endtask

	task automatic take_varint_byte(logic [7:0] b);
		logic [63:0] v;
		if (acc_n >= 9) begin
			flag_error(); return;
		end
		acc |= {57'd0, b[6:0]} << (7 * acc_n);
		acc_n++;
		if (b[7]) return;
		v = acc; acc = 0; acc_n = 0;
		if (phase == PH_TAG) take_tag(v);
		else if (phase == PH_VALUE) begin
			if (lvl == 0 && (fnum == 2 || fnum == 3))
				add_rec(fnum == 2 ? KIND_TASK_ID : KIND_ERR_CODE, v[31:0], 1'b1);
			phase = PH_TAG;
		end else
			take_length(v);
	endtask

	task automatic decode_byte(logic [7:0] b, logic lb);
		step_recs = {};
		if (!errs[2]) begin
			if (lvl >= 1) blk_left = blk_left - 1;
			if (lvl == 2) line_left = line_left - 1;
			case (phase)
				PH_TAG, PH_VALUE, PH_LENGTH: take_varint_byte(b);
				PH_FIXED: begin
					if (word_n < 3) begin
						word |= {24'd0, b} << (8 * word_n); word_n++;
					end else begin
						add_rec(fnum == 3 ? KIND_RATE : fnum[3:0], word | {b, 24'd0}, 1'b1);
						word = 0; word_n = 0; phase = PH_TAG;
					end
				end
				PH_TEXT: begin
					add_rec(KIND_TEXT, {24'd0, b}, 1'b1);
					skip_left = skip_left - 1;
					if (skip_left == 0) phase = PH_TAG;
				end
				PH_SKIP: begin
					skip_left = skip_left - 1;
					if (skip_left == 0) phase = PH_TAG;
				end
				default: ;
			endcase
			if (lvl == 2 && line_left == 0) begin
				if (phase != PH_TAG) errs |= ERR_LINE;
				add_rec(KIND_LINE_END, 0, !errs[0]);
				errs &= ~ERR_LINE; acc = 0; acc_n = 0; lvl = 1; phase = PH_TAG;
			end
			if (lvl == 1 && blk_left == 0) begin
				errs &= ~ERR_BLOCK; acc = 0; acc_n = 0; lvl = 0; phase = PH_TAG;
			end
		end
		if (lb) begin
			if (lvl != 0 || phase != PH_TAG) errs |= ERR_TOP;
			add_rec(KIND_DONE, 0, !errs[2]);
			clear_decoder();
		end
		if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
		expected_recs = {expected_recs, step_recs};
	endtask

	// stimulus builders
	function automatic byte_q_t enc_varint(logic [63:0] v);
		byte_q_t q;
		do begin
			q = {q, {((v >> 7) != 64'd0), v[6:0]}};
			v = v >> 7;
		end while (v != 0);
		return q;
	endfunction

	function automatic logic [63:0] rand_wide();
		return {$urandom, $urandom} >> $urandom_range(1, 63);
	endfunction

	function automatic byte_q_t make_line();
		byte_q_t q, t;
		int n;
		q = {};
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 5))
				0, 1: begin
					n = $urandom_range(0, 6);
					t = {};
					repeat (n) t = {t, 8'($urandom)};
					q = {q, 8'h12, enc_varint(64'(n)), t};
				end
				2, 3: begin
					n = $urandom_range(0, 4);
					q = {q, (n == 0) ? 8'h1D : 8'((n + 4) * 8 + 5),
						8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
				end
				4: q = {q, 8'h48, enc_varint(rand_wide())};
				default: q = {q, 8'h51, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
			endcase
		end
		return q;
	endfunction

	function automatic byte_q_t make_message();
		byte_q_t q, blk, ln;
		q = {};
		if ($urandom_range(0, 3) != 0) q = {q, 8'h10, enc_varint(rand_wide())};
		if ($urandom_range(0, 1)) q = {q, 8'h18, enc_varint(64'($urandom_range(0, 300)))};
		if ($urandom_range(0, 7) != 0) begin
			blk = {};
			repeat ($urandom_range(0, 3)) begin
				ln = make_line();
				blk = {blk, 8'h0A, enc_varint(64'(ln.size())), ln};
			end
			if ($urandom_range(0, 3) == 0) blk = {blk, 8'h15, 8'h01, 8'h02, 8'h03, 8'h04};
			q = {q, 8'h22, enc_varint(64'(blk.size())), blk};
		end
		if ($urandom_range(0, 5) == 0) q = {q, 8'h3A, 8'h02, 8'($urandom), 8'($urandom)};
		if (q.size() == 0) q = {8'h18, 8'h00};
		return q;
	endfunction

	task automatic queue_message(byte_q_t q);
		in_beat_t bt;
		foreach (q[i]) begin
			bt = '{data: q[i], last: i == q.size() - 1};
			byte_stream = {byte_stream, bt};
		end
		msgs_built++;
	endtask

	// driver
	always @(negedge clk) begin
		in_beat_t nxt;
		if (arst_n && (!in_valid || in_took)) begin
			if (byte_stream.size() > 0 &&
					(($urandom_range(0, 99) >= 21) || (bytes_sent > 120 && bytes_sent < 220))) begin
				nxt = byte_stream.pop_front();
				in_valid <= 1'b1;
				data_byte <= nxt.data;
				last_byte <= nxt.last;
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver with one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= 300 && stall_cycles < 420) out_ready <= 1'b0;
			else if (stall_cycles >= 900 && stall_cycles < 1200) out_ready <= 1'b1;
			else out_ready <= $urandom_range(0, 99) >= 21;
		end
	end

	// monitor
	int idle_cycles;
	always @(posedge clk) begin
		rec_beat_t exp_rec;
		in_took <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			decode_byte(data_byte, last_byte);
			bytes_sent++;
		end
		if (out_valid && out_ready) begin
			recs_seen++;
			if (expected_recs.size() == 0) begin
				$error("unexpected record kind %0d value %h", record_kind, record_value);
				fail_count++;
			end else begin
				exp_rec = expected_recs.pop_front();
				if (record_kind !== exp_rec.kind) begin
					$error("record_kind exp %0d got %0d", exp_rec.kind, record_kind);
					fail_count++;
				end
				if (record_value !== exp_rec.value) begin
					$error("record_value exp %h got %h", exp_rec.value, record_value);
					fail_count++;
				end
				if (record_ok !== exp_rec.ok) begin
					$error("record_ok exp %0b got %0b", exp_rec.ok, record_ok);
					fail_count++;
				end
				if (last_of_run !== exp_rec.last) begin
					$error("last_of_run exp %0b got %0b", exp_rec.last, last_of_run);
					fail_count++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else if (idle_cycles >= 3000) begin
			$display("tb: failure");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		byte_q_t q;
		arst_n = 1'b0; in_valid = 1'b0; data_byte = 0; last_byte = 0; out_ready = 1'b0;
		in_took = 1'b0; fail_count = 0; bytes_sent = 0; recs_seen = 0; msgs_built = 0;
		stall_cycles = 0; idle_cycles = 0;
		clear_decoder();
		// lone byte that leaves a field open, longest varint, too-long varint
		queue_message({8'h00});
		queue_message({8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
			8'h18, 8'h00});
		queue_message({8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h01});
		// wrong and unknown wire types, oversized top-level length
		queue_message({8'h11, 8'h05});
		queue_message({8'h23, 8'h05});
		queue_message({8'h22, 8'h80, 8'h80, 8'h80, 8'h08});
		// line longer than its block, then a line with every field kind that ends in an unknown wire type
		queue_message({8'h22, 8'h03, 8'h0A, 8'h05, 8'h00});
		queue_message({8'h22, 8'h24, 8'h0A, 8'h22, 8'h12, 8'h02, 8'h41, 8'h42,
			8'h1D, 8'h01, 8'h02, 8'h03, 8'h04, 8'h2D, 8'h00, 8'h00, 8'h80, 8'h3F,
			8'h35, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h3D, 8'h11, 8'h22, 8'h33, 8'h44,
			8'h45, 8'h00, 8'h00, 8'h00, 8'h80, 8'h12, 8'h00, 8'h5B, 8'h12, 8'h01});
		while (byte_stream.size() < 420) begin
			q = make_message();
			case ($urandom_range(0, 9))
				0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
				1: q = q[0:$urandom_range(0, q.size() - 1)];
				2: begin
					q = {};
					repeat ($urandom_range(1, 10)) q = {q, 8'($urandom)};
				end
				default: ;
			endcase
			queue_message(q);
		end
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (byte_stream.size() != 0 || in_valid) @(posedge clk);
		while (expected_recs.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d responses, %0d bytes, %0d records, with stalls on both sides",
			msgs_built, bytes_sent, recs_seen);
		if (fail_count == 0 && expected_recs.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
